// File: src/u2u8_pkg.sv
package u2u8_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [5:0]  SURR_HIGH_TAG = 6'b110110;  // 0xD800 .. 0xDBFF
   localparam logic [5:0]  SURR_LOW_TAG  = 6'b110111;  // 0xDC00 .. 0xDFFF
   localparam logic [15:0] SURR_HIGH_BASE = 16'hD800;
   localparam logic [20:0] SUPP_BASE      = 21'h10000;

   localparam logic [7:0] LEAD1_MASK = 8'h00;
   localparam logic [7:0] LEAD2_MASK = 8'hC0;
   localparam logic [7:0] LEAD3_MASK = 8'hE0;
   localparam logic [7:0] LEAD4_MASK = 8'hF0;
   localparam logic [7:0] CONT_MASK  = 8'h80;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        end_of_string;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] utf8_byte;
      logic       last_byte;
   } rsp_payload_type;

   // One queue entry: an optional flushed high surrogate, then an optional code point.
   typedef struct packed {
      logic        flush_valid;
      logic [9:0]  flush_bits;
      logic        main_valid;
      logic [20:0] main_cp;
      logic        last;
   } job_type;

   // Queue status seen by the front and back ends.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [2:0] utf8_len(input logic [20:0] cp);
      logic [2:0] len;
      if (cp < 21'h80) begin
         len = 3'd1;
      end else if (cp < 21'h800) begin
         len = 3'd2;
      end else if (cp < SUPP_BASE) begin
         len = 3'd3;
      end else begin
         len = 3'd4;
      end
      return len;
   endfunction

   // Byte idx (0 = lead) of the len-byte encoding of cp.
   function automatic logic [7:0] utf8_byte_at(input logic [20:0] cp, input logic [2:0] len,
                                               input logic [1:0] idx);
      logic [7:0] b;
      logic [1:0] grp;
      grp = 2'(len - 3'd1 - {1'b0, idx});
      if (idx == 2'd0) begin
         case (len)
            3'd1:    b = LEAD1_MASK | {1'b0, cp[6:0]};
            3'd2:    b = LEAD2_MASK | {3'b000, cp[10:6]};
            3'd3:    b = LEAD3_MASK | {4'b0000, cp[15:12]};
            default: b = LEAD4_MASK | {5'b00000, cp[20:18]};
         endcase
      end else begin
         case (grp)
            2'd0:    b = CONT_MASK | {2'b00, cp[5:0]};
            2'd1:    b = CONT_MASK | {2'b00, cp[11:6]};
            default: b = CONT_MASK | {2'b00, cp[17:12]};
         endcase
      end
      return b;
   endfunction

endpackage

// File: src/utf16_to_utf8_encoder_core.sv
// UTF-16 to UTF-8 transcoder. Each req transaction carries one 16-bit code unit and an
// end_of_string flag; each rsp transaction carries one UTF-8 byte, with last_byte set on
// the final byte of the string. A high surrogate is held until the next unit: a following
// low surrogate makes a 4-byte sequence, anything else flushes the held surrogate as a
// 3-byte sequence before the new unit. Lone low surrogates encode as 3 bytes. end_of_string
// flushes anything held. Timing: the front end takes one unit per cycle while the job queue
// (QueueDepth entries) has room; the back end sends one byte per cycle while a job is queued
// and rsp_stall is low. A unit yields 1 to 3 bytes for BMP values, 4 per surrogate pair
// (two units), and up to 6 when a held surrogate is flushed. A held high surrogate in
// mid-string produces no byte. Sustained throughput is set by the one-byte rsp port.
// When idle, a unit passes through the job queue and the registered output to the rsp port.
module utf16_to_utf8_encoder_core #(
   parameter int QueueDepth = u2u8_pkg::QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   // code unit input
   input  logic                      req_valid,
   output logic                      req_stall,
   input  u2u8_pkg::req_payload_type req_payload,
   // byte output
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output u2u8_pkg::rsp_payload_type rsp_payload
);

   u2u8_pkg::queue_status_type q_status;
   u2u8_pkg::job_type          push_job, head_job;
   logic                       push, pop, held_valid;

   // Front end: surrogate pairing, emits one job per unit that yields bytes.
   u2u8_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .q_status   (q_status),
      .push       (push),
      .push_job   (push_job),
      .held_valid (held_valid)
   );

   // Job queue decouples unit intake from byte output.
   u2u8_queue #(
      .QueueDepth(QueueDepth)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_job(push_job),
      .pop     (pop),
      .head_job(head_job),
      .q_status(q_status)
   );

   // Back end: serializes each job into bytes, registered output.
   u2u8_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

`ifndef SYNTHESIS
   // no push into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("job pushed into full queue");

   // no pop from an empty queue
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("job popped from empty queue");

   // end of string leaves nothing held
   a_eos_flush: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_payload.end_of_string) |=> !held_valid)
      else $error("surrogate still held after end of string");
`endif

endmodule

// File: src/u2u8_front.sv
module u2u8_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  u2u8_pkg::req_payload_type  req_payload,
   input  u2u8_pkg::queue_status_type q_status,
   output logic                       push,
   output u2u8_pkg::job_type          push_job,
   output logic                       held_valid
);

   logic       held_valid_ff, held_valid_in;
   logic [9:0] held_bits_ff, held_bits_in;
   logic       accept, is_low, is_high;

   assign req_stall  = q_status.full;
   assign accept     = req_valid && !q_status.full;
   assign is_low     = req_payload.code_unit[15:10] == u2u8_pkg::SURR_LOW_TAG;
   assign is_high    = req_payload.code_unit[15:10] == u2u8_pkg::SURR_HIGH_TAG;
   assign held_valid = held_valid_ff;

   always_comb begin
      held_valid_in          = held_valid_ff;
      held_bits_in           = held_bits_ff;
      push_job.flush_valid   = 1'b0;
      push_job.flush_bits    = held_bits_ff;
      push_job.main_valid    = 1'b0;
      push_job.main_cp       = {5'b00000, req_payload.code_unit};
      push_job.last          = req_payload.end_of_string;
      if (accept) begin
         held_valid_in = 1'b0;
         held_bits_in  = '0;
         if (held_valid_ff && is_low) begin
            // surrogate pair completes
            push_job.main_valid = 1'b1;
            push_job.main_cp    = u2u8_pkg::SUPP_BASE +
                                  {1'b0, held_bits_ff, req_payload.code_unit[9:0]};
         end else begin
            push_job.flush_valid = held_valid_ff;
            if (is_high && !req_payload.end_of_string) begin
               held_valid_in = 1'b1;
               held_bits_in  = req_payload.code_unit[9:0];
            end else begin
               push_job.main_valid = 1'b1;
            end
         end
      end
   end

   assign push = accept && (push_job.flush_valid || push_job.main_valid);

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         held_bits_ff  <= '0;
      end else begin
         held_valid_ff <= held_valid_in;
         held_bits_ff  <= held_bits_in;
      end
   end

endmodule

// File: src/u2u8_queue.sv
module u2u8_queue #(
   parameter int QueueDepth = u2u8_pkg::QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  u2u8_pkg::job_type          push_job,
   input  logic                       pop,
   output u2u8_pkg::job_type          head_job,
   output u2u8_pkg::queue_status_type q_status
);

   localparam int PtrWidth = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CntWidth = $clog2(QueueDepth + 1);

   u2u8_pkg::job_type     entries_ff [QueueDepth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   count_ff, count_in;

   assign q_status.full  = count_ff == CntWidth'(QueueDepth);
   assign q_status.empty = count_ff == '0;
   assign head_job       = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// File: src/u2u8_back.sv
module u2u8_back (
   input  logic                       clock,
   input  logic                       reset,
   input  u2u8_pkg::queue_status_type q_status,
   input  u2u8_pkg::job_type          head_job,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output u2u8_pkg::rsp_payload_type  rsp_payload
);

   logic                      in_main_ff, in_main_in;
   logic [1:0]                idx_ff, idx_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   u2u8_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic        cur_is_flush, seg_done, job_done, advance;
   logic [20:0] cur_cp;
   logic [2:0]  cur_len;

   assign cur_is_flush = head_job.flush_valid && !in_main_ff;
   assign cur_cp       = cur_is_flush ?
                         {5'b00000, u2u8_pkg::SURR_HIGH_BASE | {6'b000000, head_job.flush_bits}}
                         : head_job.main_cp;
   assign cur_len      = cur_is_flush ? 3'd3 : u2u8_pkg::utf8_len(cur_cp);
   assign seg_done     = idx_ff == 2'(cur_len - 3'd1);
   assign job_done     = seg_done && (!cur_is_flush || !head_job.main_valid);
   assign advance      = !q_status.empty && (!rsp_valid_ff || !rsp_stall);
   assign pop          = advance && job_done;

   always_comb begin
      in_main_in     = in_main_ff;
      idx_in         = idx_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      if (advance) begin
         rsp_valid_in             = 1'b1;
         rsp_payload_in.utf8_byte = u2u8_pkg::utf8_byte_at(cur_cp, cur_len, idx_ff);
         rsp_payload_in.last_byte = job_done && head_job.last;
         if (job_done) begin
            in_main_in = 1'b0;
            idx_in     = '0;
         end else if (seg_done) begin
            in_main_in = 1'b1;
            idx_in     = '0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_main_ff   <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_main_ff   <= in_main_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule
